@@ design/median_filter_3x3_defines.svh @@
// Assertion macros shared by the median filter RTL.
// Included by the top level; depends on nothing else.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MF3_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("median filter check failed");

// Next-cycle implication, checked outside reset.
`define MF3_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("median filter check failed");

`endif

@@ design/mf3_pkg.sv @@
// Shared types and constants of the 3x3 median filter.
// Used by every module of the block; depends on nothing.
package mf3_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int PixW        = 8;
  localparam int RowW        = 12;
  localparam int CenterColW  = 10;
  localparam int FrameWidthW = 11;
  localparam int FrameHeightW = 12;
  localparam int MaxHeight   = 4095;
  localparam int LineW       = 2 * PixW;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 12;
  localparam int InDataW     = 8;
  localparam int OutDataW    = 32;

  localparam logic [FrameWidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [FrameHeightW-1:0] HeightReset = 12'd480;

  // Register indexes of the configuration channel.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  typedef logic [PixW-1:0] pix_t;

  // Position tag that travels with a window through the sorter.
  typedef struct packed {
    logic                  last;
    logic [RowW-1:0]       row;
    logic [CenterColW-1:0] col;
  } pos_t;

endpackage

@@ design/median_filter_3x3.sv @@
// Top level of the streaming 3x3 median filter.
// Depends on mf3_pkg, mf3_line_store, mf3_median9 and median_filter_3x3_defines.svh.
// Usage:
//   Pixels enter on the s_axis channel in raster order, one per transfer.
//   Frame geometry is set on the cfg channel (index 0 width, index 1 height)
//   while the block is idle; cfg_ready_o is always high.
//   For each pixel at row >= 2 and column >= 2 one transfer leaves on m_axis:
//   the median of the 3x3 window centered one row up and one column left,
//   with that center's row and column; tlast marks the last result of a frame.
//   Border positions give no transfer.
// Pipeline and throughput:
//   A result moves from stage 1 through the sorter stages into the output register.
//   One pixel is taken every cycle while s_axis_tready is high; the line store is read
//   when a pixel is taken and written when it leaves stage 1, one entry per column.
// Reset:
//   Counters restart at row 0, column 0; geometry returns to 640 x 480.
//   The line store is not cleared; rows 0 and 1 of a frame refill it.
// Stall:
//   When m_axis_tready is low, results queue in the pipeline stages;
//   s_axis_tready falls only when every stage holds a result or pixel.
`include "median_filter_3x3_defines.svh"

module median_filter_3x3 #(
  parameter int MaxWidth = mf3_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mf3_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CfgDataW-1:0]  cfg_data_i,
  // Pixel input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mf3_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] pixel
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mf3_pkg::OutDataW-1:0]  m_axis_tdata,  // [7:0] median_value,
                                                       // [19:8] center_row,
                                                       // [29:20] center_col
  output logic                          m_axis_tlast   // frame_last
);
  import mf3_pkg::*;

  localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int ExtW = ($clog2(MaxWidth + 1) > FrameWidthW) ?
                        $clog2(MaxWidth + 1) : FrameWidthW;
  localparam int RowExtW = RowW + 1;

  // Configuration registers.
  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthReset;
      frame_height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFrameWidth:  frame_width_q  <= cfg_data_i[FrameWidthW-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i[FrameHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry, saturated to the supported range.
  logic [ExtW-1:0]    eff_w;
  logic [RowExtW-1:0] eff_h;

  always_comb begin
    eff_w = ExtW'(frame_width_q);
    if (eff_w < ExtW'(3)) eff_w = ExtW'(3);
    if (eff_w > ExtW'(MaxWidth)) eff_w = ExtW'(MaxWidth);
    eff_h = RowExtW'(frame_height_q);
    if (eff_h < RowExtW'(3)) eff_h = RowExtW'(3);
    if (eff_h > RowExtW'(MaxHeight)) eff_h = RowExtW'(MaxHeight);
  end

  // Position counters and the position of the arriving pixel.
  logic [ColW-1:0]    col_cnt_q, col_cnt_d;
  logic [RowW-1:0]    row_cnt_q, row_cnt_d;
  logic [ColW-1:0]    col_now;
  logic [RowW-1:0]    row_now;
  logic [RowExtW-1:0] row_pre, row_inc;
  logic [ExtW-1:0]    col_inc, col_m1;
  logic               col_wrap, col_end, row_end;
  logic               emit_now;
  pos_t               pos_now;
  logic               accept;

  always_comb begin
    col_wrap = ExtW'(col_cnt_q) >= eff_w;
    col_now  = col_wrap ? '0 : col_cnt_q;
    row_pre  = RowExtW'(row_cnt_q) + RowExtW'(col_wrap);
    row_now  = (row_pre >= eff_h) ? '0 : row_pre[RowW-1:0];
    col_inc  = ExtW'(col_now) + ExtW'(1);
    row_inc  = RowExtW'(row_now) + RowExtW'(1);
    col_end  = col_inc >= eff_w;
    row_end  = row_inc >= eff_h;
    col_m1   = ExtW'(col_now) - ExtW'(1);
    emit_now = (row_now >= RowW'(2)) && (ExtW'(col_now) >= ExtW'(2));
    pos_now.last = (row_inc == eff_h) && (col_inc == eff_w);
    pos_now.row  = row_now - RowW'(1);
    pos_now.col  = col_m1[CenterColW-1:0];
    col_cnt_d = col_end ? '0 : col_inc[ColW-1:0];
    if (col_end) begin
      row_cnt_d = row_end ? '0 : row_inc[RowW-1:0];
    end else begin
      row_cnt_d = row_now;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Stage 1: pixel waits for its line store entry.
  logic            v1_q;
  pix_t            px1_q;
  logic [ColW-1:0] col1_q;
  logic            emit1_q;
  pos_t            pos1_q;
  logic            med_in_ready;
  logic            leave1;

  assign s_axis_tready = !v1_q || med_in_ready;
  assign leave1        = v1_q && med_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q   <= s_axis_tdata[PixW-1:0];
      col1_q  <= col_now;
      emit1_q <= emit_now;
      pos1_q  <= pos_now;
    end
  end

  // Line store: read on transfer, write back when the pixel moves on.
  logic [LineW-1:0] line_rd;
  pix_t             top_px, mid_px;

  assign top_px = line_rd[LineW-1:PixW];
  assign mid_px = line_rd[PixW-1:0];

  mf3_line_store #(
    .Depth(MaxWidth)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(col_now),
    .rd_data_o(line_rd),
    .wr_en_i  (leave1),
    .wr_addr_i(col1_q),
    .wr_data_i({mid_px, px1_q})
  );

  // Sliding window of the two previous columns, newer column low.
  logic [6*PixW-1:0]    win_q;
  logic [3*PixW-1:0]    new_col, c1, c2;
  logic [8:0][PixW-1:0] nine;

  assign new_col = {top_px, mid_px, px1_q};
  assign c1      = win_q[3*PixW-1:0];
  assign c2      = win_q[6*PixW-1:3*PixW];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nine[3*r]     = c2[PixW*r +: PixW];
      nine[3*r + 1] = c1[PixW*r +: PixW];
      nine[3*r + 2] = new_col[PixW*r +: PixW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (leave1) begin
      win_q <= {c1, new_col};
    end
  end

  // Median sorter and output register.
  pix_t med_out;
  pos_t pos_out;

  mf3_median9 u_median9 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q && emit1_q),
    .in_ready_o  (med_in_ready),
    .in_pix_i    (nine),
    .in_pos_i    (pos1_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_median_o(med_out),
    .out_pos_o   (pos_out)
  );

  assign m_axis_tdata = OutDataW'({pos_out.col, pos_out.row, med_out});
  assign m_axis_tlast = pos_out.last;

  // Checks.
  `MF3_ASSERT_IMPLY(a_ready_when_out_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `MF3_ASSERT_NEXT(a_accept_fills_stage1, clk_i, rst_ni, accept, v1_q)
  `MF3_ASSERT_IMPLY(a_center_row_interior, clk_i, rst_ni, v1_q && emit1_q, pos1_q.row != '0)

endmodule

@@ design/mf3_line_store.sv @@
// Line store: single-port-write, single-port-read memory with a registered read.
// Holds the two previous rows of each column; depends on mf3_pkg.
module mf3_line_store #(
  parameter int Depth = mf3_pkg::MaxWidthDef,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [mf3_pkg::LineW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [mf3_pkg::LineW-1:0] wr_data_i
);
  import mf3_pkg::*;

  logic [LineW-1:0] mem [Depth];
  logic [LineW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/mf3_median9.sv @@
// Pipelined median-of-nine sorter with per-stage stall control.
// Four register stages, the last one is the output register; depends on mf3_pkg.
module mf3_median9 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [8:0][mf3_pkg::PixW-1:0] in_pix_i,
  input  mf3_pkg::pos_t               in_pos_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mf3_pkg::PixW-1:0]    out_median_o,
  output mf3_pkg::pos_t               out_pos_o
);
  import mf3_pkg::*;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Ascending order of three values, lowest in element 0.
  function automatic logic [2:0][PixW-1:0] sort3(pix_t a, pix_t b, pix_t c);
    logic [2:0][PixW-1:0] s;
    s[0] = min2(min2(a, b), c);
    s[1] = med3(a, b, c);
    s[2] = max2(max2(a, b), c);
    return s;
  endfunction

  logic                 v2_q, v3_q, v4_q, v5_q;
  logic                 ld2, ld3, ld4, ld5;
  logic [8:0][PixW-1:0] pix2_q;
  logic [2:0][2:0][PixW-1:0] srt3_q;
  pix_t                 lo4_q, mid4_q, hi4_q;
  pix_t                 med5_q;
  pos_t                 pos2_q, pos3_q, pos4_q, pos5_q;

  // A stage loads when it is empty or its content moves on.
  assign ld5 = !v5_q || out_ready_i;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign in_ready_o = ld2;

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (ld2) v2_q <= in_valid_i;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
    end
  end

  // Data path: capture, sort rows, reduce to three, final median.
  always_ff @(posedge clk_i) begin
    if (ld2) begin
      pix2_q <= in_pix_i;
      pos2_q <= in_pos_i;
    end
    if (ld3) begin
      for (int g = 0; g < 3; g++) begin
        srt3_q[g] <= sort3(pix2_q[3*g], pix2_q[3*g+1], pix2_q[3*g+2]);
      end
      pos3_q <= pos2_q;
    end
    if (ld4) begin
      lo4_q  <= max2(max2(srt3_q[0][0], srt3_q[1][0]), srt3_q[2][0]);
      mid4_q <= med3(srt3_q[0][1], srt3_q[1][1], srt3_q[2][1]);
      hi4_q  <= min2(min2(srt3_q[0][2], srt3_q[1][2]), srt3_q[2][2]);
      pos4_q <= pos3_q;
    end
    if (ld5) begin
      med5_q <= med3(lo4_q, mid4_q, hi4_q);
      pos5_q <= pos4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign out_median_o = med5_q;
  assign out_pos_o    = pos5_q;

endmodule

@@ sim/median_filter_3x3_test.sv @@
// Self-checking testbench for the streaming 3x3 median filter median_filter_3x3.
// Drives pixel frames and geometry writes with random idling and predicts every
// result in its own model of the block. Depends on mf3_pkg and the filter RTL.
module median_filter_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  // Unassigned register indexes; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  localparam int DrainCycles   = 12;    // settling time after the last expected median
  localparam int WatchdogLimit = 2000;  // cycles without any transfer
  localparam int RandomItems   = 950;
  localparam int LongHold      = 300;

  typedef enum int {PixRandom, PixExtreme, PixNarrow} pix_mode_e;

  // One predicted median transfer.
  typedef struct {
    pix_t                  median;
    logic [RowW-1:0]       row;
    logic [CenterColW-1:0] col;
    logic                  last;
  } median_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  // Predictor state: a copy of the filter's line history, window and counters.
  bit [LineW-1:0]        row_history [MaxWidthDef];
  bit [6*PixW-1:0]       window_cols;
  int unsigned           next_col;
  int unsigned           next_row;
  bit [FrameWidthW-1:0]  frame_width_reg;
  bit [FrameHeightW-1:0] frame_height_reg;
  median_result_t        pending_medians[$];

  int error_count;
  int src_gap_max;
  int sink_gap_max;
  int sink_hold_cycles;
  int quiet_cycles;

  median_filter_3x3 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Effective geometry: the registers saturated to the supported range.
  function automatic int active_width();
    if (frame_width_reg < 3) return 3;
    if (frame_width_reg > MaxWidthDef) return MaxWidthDef;
    return frame_width_reg;
  endfunction

  function automatic int active_height();
    if (frame_height_reg < 3) return 3;
    if (frame_height_reg > MaxHeight) return MaxHeight;
    return frame_height_reg;
  endfunction

  // Advance the predicted filter by one accepted pixel and queue its median.
  function automatic void filter_pixel(input pix_t pix);
    int unsigned    w, h, col, row, lt, le;
    bit [LineW-1:0] hist;
    bit [23:0]      newest, prev1, prev2;
    pix_t           nbr[9];
    median_result_t res;
    w = active_width();
    h = active_height();
    // A geometry change can leave the counters past the new limits.
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    col = next_col;
    row = next_row;

    hist = row_history[col % MaxWidthDef];
    row_history[col % MaxWidthDef] = {hist[PixW-1:0], pix};
    newest = {hist, pix};
    prev1 = window_cols[23:0];
    prev2 = window_cols[47:24];

    if (row >= 2 && col >= 2) begin
      for (int k = 0; k < 3; k++) begin
        nbr[k]     = prev2[8*k +: 8];
        nbr[3 + k] = prev1[8*k +: 8];
        nbr[6 + k] = newest[8*k +: 8];
      end
      // The median is the value with at most four below it and at least five at or below.
      for (int i = 0; i < 9; i++) begin
        lt = 0;
        le = 0;
        for (int j = 0; j < 9; j++) begin
          if (nbr[j] < nbr[i]) lt++;
          if (nbr[j] <= nbr[i]) le++;
        end
        if (lt <= 4 && le > 4) res.median = nbr[i];
      end
      res.row  = RowW'(row - 1);
      res.col  = CenterColW'(col - 1);
      res.last = (row == h - 1) && (col == w - 1);
      pending_medians.push_back(res);
    end

    window_cols = {prev1, newest};
    next_col = col + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = row + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  function automatic pix_t draw_pixel(input pix_mode_e mode, input pix_t base);
    case (mode)
      PixExtreme: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PixNarrow:  return base + pix_t'($urandom_range(0, 3));
      default:    return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Offer one pixel after a random gap; returns at the falling edge after the
  // transfer with tvalid still high.
  task automatic send_pixel(input pix_t pix);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pix;
    do @(posedge clk_i); while (!s_axis_tready);
    filter_pixel(pix);
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int count, input pix_mode_e mode);
    pix_t base;
    base = pix_t'($urandom_range(0, 255));
    repeat (count) send_pixel(draw_pixel(mode, base));
  endtask

  // Stop offering pixels, let every expected median arrive, then let the
  // pipeline settle since border pixels may still be in flight.
  task automatic wait_pipeline_idle();
    s_axis_tvalid = 1'b0;
    while (pending_medians.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegFrameWidth:  frame_width_reg  = data[FrameWidthW-1:0];
      RegFrameHeight: frame_height_reg = data[FrameHeightW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_geometry(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    wait_pipeline_idle();
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
  endtask

  // Part of a row at the reset geometry of 640 columns, then a shrink to 3x3
  // that wraps the counters into row 1 and completes that frame.
  task automatic test_reset_geometry();
    send_pixels(40, PixRandom);
    set_geometry(3, 3);
    send_pixels(3 * 2, PixRandom);
  endtask

  // Hand-picked 3x3 frames: opposite extremes, then single-bit values ending in 8'h7F and 8'hFF.
  task automatic test_directed_frames();
    pix_t frame_a[9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
    pix_t frame_b[9] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F, 8'hFF};
    set_geometry(3, 3);
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    foreach (frame_b[i]) send_pixel(frame_b[i]);
  endtask

  // Saturation and masking of the geometry registers.
  task automatic test_geometry_limits();
    set_geometry(0, 0);
    send_pixels(9, PixRandom);
    set_geometry(12'h805, 4);
    send_pixels(5 * 4, PixExtreme);
    // Writes to unassigned indexes must leave a 4x3 geometry in place.
    set_geometry(4, 3);
    write_reg(RegSpareA, CfgDataW'($urandom_range(0, 4095)));
    write_reg(RegSpareB, CfgDataW'($urandom_range(0, 4095)));
    send_pixels(4 * 3, PixRandom);
  endtask

  // Shrink the frame while it is being received; the counters wrap on the
  // next pixel and nothing is cleared.
  task automatic test_midframe_resize();
    set_geometry(12, 8);
    send_pixels(12 * 4 + 7, PixRandom);
    set_geometry(9, 8);
    send_pixels(2 + 9, PixRandom);
    set_geometry(5, 8);
    send_pixels(5 + 3, PixNarrow);
    set_geometry(3, 8);
    send_pixels(3 * 4, PixRandom);
    set_geometry(3, 3);
    send_pixels(9 * 2, PixRandom);
  endtask

  // The sink holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    set_geometry(6, 20);
    src_gap_max = 0;
    sink_hold_cycles = LongHold;
    send_pixels(6 * 20, PixRandom);
    src_gap_max = 6;
  endtask

  // Random geometries and content; some frames are cut short.
  task automatic test_random_frames();
    int        sent;
    int        w;
    int        h;
    int        frame_px;
    int        count;
    pix_mode_e mode;
    sent = 0;
    while (sent < RandomItems) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(3, 6);
      // Widening inside a frame would read columns that hold no pixels yet.
      if ((next_col != 0 || next_row != 0) && w > active_width()) w = active_width();
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      set_geometry(CfgDataW'(w), CfgDataW'(h));
      frame_px = active_width() * active_height();
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame_px) : frame_px;
      case ($urandom_range(0, 5))
        0:       mode = PixExtreme;
        1:       mode = PixNarrow;
        default: mode = PixRandom;
      endcase
      send_pixels(count, mode);
      sent += count;
    end
    src_gap_max  = 6;
    sink_gap_max = 6;
  endtask

  // Result sink: random stalls, then checks each transfer against the oldest
  // predicted median.
  initial begin : result_sink
    int             stall;
    median_result_t want;
    pix_t           got_median;
    logic [RowW-1:0] got_row;
    logic [CenterColW-1:0] got_col;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_median = m_axis_tdata[PixW-1:0];
      got_row    = m_axis_tdata[PixW +: RowW];
      got_col    = m_axis_tdata[PixW + RowW +: CenterColW];
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("result with none expected, tdata 0x%08h", m_axis_tdata));
      end else begin
        want = pending_medians.pop_front();
        if (got_median !== want.median)
          report_mismatch($sformatf("median_value %0d, expected %0d", got_median, want.median));
        if (got_row !== want.row)
          report_mismatch($sformatf("center_row %0d, expected %0d", got_row, want.row));
        if (got_col !== want.col)
          report_mismatch($sformatf("center_col %0d, expected %0d", got_col, want.col));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("frame_last %0b, expected %0b", m_axis_tlast, want.last));
      end
    end
  end

  // Watchdog: count cycles in which no transfer happens on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WatchdogLimit);
    $display("timeout: no transfer for %0d cycles", WatchdogLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : test_sequence
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = RegFrameWidth;
    cfg_data_i       = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    quiet_cycles     = 0;
    error_count      = 0;
    sink_hold_cycles = 0;
    src_gap_max      = 6;
    sink_gap_max     = 6;
    window_cols      = '0;
    next_col         = 0;
    next_row         = 0;
    frame_width_reg  = WidthReset;
    frame_height_reg = HeightReset;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_geometry();
    test_directed_frames();
    test_geometry_limits();
    test_midframe_resize();
    test_backpressure();
    test_random_frames();

    wait_pipeline_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mf3_pkg.sv
design/mf3_line_store.sv
design/mf3_median9.sv
design/median_filter_3x3.sv
sim/median_filter_3x3_test.sv
